/* rtl/core/ce_pkg.sv */
// ce_pkg: shared widths, constants and controller/datapath command and status
// structs for the cross-entropy loss and gradient block. No dependencies.
package ce_pkg;

   localparam int FRAC_BITS = 16;

   localparam int PROB_W   = 17;
   localparam int GRAD_W   = 34;
   localparam int LOSS_W   = 24;
   localparam int BACC_W   = 40;
   localparam int DVD_W    = 40;
   localparam int DVS_W    = 34;
   localparam int LOG_W    = 30;
   localparam int Y_W      = 31;
   localparam int EXP_W    = 4;
   localparam int NEGL2_W  = 35;
   localparam int LO_W     = 17;
   localparam int HI_W     = NEGL2_W - LO_W;
   localparam int PROD_W   = 63;
   localparam int NL_W     = 21;
   localparam int TERM_W   = 21;
   localparam int LN2_W    = 28;
   localparam int ROUND_SH = 58 - FRAC_BITS;

   localparam logic [LN2_W-1:0]  LN2_Q28 = 28'd186065279;
   localparam logic [PROB_W-1:0] BATCH_SIZE_RESET = 17'd1;

   typedef struct packed {
      logic load;
      logic keep_grad;
      logic ln_hi;
      logic ln_lo;
      logic term;
      logic acc;
      logic close;
      logic avg_start;
      logic avg_keep;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic log_busy;
      logic last_class;
      logic last_sample;
      logic out_free;
   } stat_type;

endpackage

/* rtl/core/ce_req_if.sv */
// ce_req_if: input word channel (valid/ready plus one probability element).
// Depends on ce_pkg for field widths.
interface ce_req_if;
   logic                        valid;
   logic                        ready;
   logic [ce_pkg::PROB_W-1:0]   prob;
   logic [ce_pkg::PROB_W-1:0]   target_weight;
   logic                        last_class;
   logic                        last_sample;

   modport source (output valid, prob, target_weight, last_class, last_sample, input ready);
   modport sink   (input valid, prob, target_weight, last_class, last_sample, output ready);
endinterface

/* rtl/core/ce_rsp_if.sv */
// ce_rsp_if: result word channel (valid/ready plus gradient and loss fields).
// Depends on ce_pkg for field widths.
interface ce_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [ce_pkg::GRAD_W-1:0]   gradient;
   logic [ce_pkg::LOSS_W-1:0]          sample_loss;
   logic                               sample_done;
   logic [ce_pkg::LOSS_W-1:0]          batch_mean;
   logic                               batch_done;

   modport source (output valid, gradient, sample_loss, sample_done, batch_mean, batch_done,
                   input ready);
   modport sink   (input valid, gradient, sample_loss, sample_done, batch_mean, batch_done,
                   output ready);
endinterface

/* rtl/core/ce_div.sv */
// ce_div: restoring serial divider, one quotient bit per cycle.
// Depends on ce_pkg for default widths.
module ce_div #(
   parameter int DVD_W = ce_pkg::DVD_W,
   parameter int DVS_W = ce_pkg::DVS_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             busy,
   output logic [DVD_W-1:0] quotient
);
   localparam int CW = $clog2(DVD_W);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W:0]   rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DVS_W:0]   rem_sh;

   always_comb begin
      rem_sh  = {rem_ff[DVS_W-1:0], quo_ff[DVD_W-1]};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sh - {1'b0, dvs_ff};
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DVD_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

/* rtl/core/ce_dp.sv */
// ce_dp: datapath - operand registers, log2 squaring unit, shared divider,
// loss accumulators and output register. Depends on ce_pkg and ce_div.
module ce_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  ce_pkg::cmd_type                   cmd,
   output ce_pkg::stat_type                  stat,
   input  logic [ce_pkg::PROB_W-1:0]         req_prob,
   input  logic [ce_pkg::PROB_W-1:0]         req_target_weight,
   input  logic                              req_last_class,
   input  logic                              req_last_sample,
   input  logic [ce_pkg::PROB_W-1:0]         batch_n,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic signed [ce_pkg::GRAD_W-1:0]  rsp_gradient,
   output logic [ce_pkg::LOSS_W-1:0]         rsp_sample_loss,
   output logic                              rsp_sample_done,
   output logic [ce_pkg::LOSS_W-1:0]         rsp_batch_mean,
   output logic                              rsp_batch_done
);
   import ce_pkg::*;

   logic [PROB_W-1:0]  t_ff, n_ff;
   logic               lc_ff, ls_ff;
   logic [GRAD_W-1:0]  grad_ff;
   logic [EXP_W-1:0]   e_ff, e_in;
   logic [Y_W-1:0]     y_ff, y_in;
   logic [LOG_W-1:0]   frac_ff;
   logic [4:0]         lcnt_ff;
   logic               lbusy_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [TERM_W-1:0]  term_ff;
   logic [LOSS_W-1:0]  sacc_ff, sl_ff, avg_ff;
   logic [BACC_W-1:0]  bacc_ff;

   logic               ov_ff;
   logic [GRAD_W-1:0]  og_ff;
   logic [LOSS_W-1:0]  osl_ff, oavg_ff;
   logic               osd_ff, obd_ff;

   logic [PROB_W-1:0]  pg;
   logic [15:0]        pc;
   logic               div_start, div_busy;
   logic [DVD_W-1:0]   dvd, quo;
   logic [DVS_W-1:0]   dvs;
   logic [61:0]        sq;
   logic [31:0]        sq_s;
   logic [NEGL2_W-1:0] negl2;
   logic [HI_W+LN2_W-1:0] hi_p;
   logic [LO_W+LN2_W-1:0] lo_p;
   logic [PROD_W:0]    rnd;
   logic [NL_W-1:0]    nl;
   logic [PROB_W+NL_W-1:0] tp;
   logic [LOSS_W:0]    ssum;
   logic [BACC_W:0]    bsum;
   logic [GRAD_W-1:0]  mag;

   // clip for the log: [1, 2^F - 1]; raise zero for the gradient
   assign pg = (req_prob == '0) ? PROB_W'(1) : req_prob;
   always_comb begin
      if (req_prob == '0) begin
         pc = 16'd1;
      end else if (req_prob[PROB_W-1]) begin
         pc = '1;
      end else begin
         pc = req_prob[15:0];
      end
      e_in = '0;
      for (int i = 0; i < 16; i++) begin
         if (pc[i]) begin
            e_in = EXP_W'(i);
         end
      end
      y_in = Y_W'(pc) << (5'd30 - 5'(e_in));
   end

   assign div_start = cmd.load | cmd.avg_start;
   assign dvd = cmd.load ? DVD_W'({req_target_weight, FRAC_BITS'(0)}) : bacc_ff;
   assign dvs = cmd.load ? (DVS_W'(pg) * DVS_W'(batch_n)) : DVS_W'(n_ff);

   ce_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd),
      .divisor  (dvs),
      .busy     (div_busy),
      .quotient (quo)
   );

   // one squaring step of the mantissa per cycle
   assign sq    = 62'(y_ff) * 62'(y_ff);
   assign sq_s  = sq[61:30];
   assign negl2 = (NEGL2_W'(FRAC_BITS) - NEGL2_W'(e_ff)) * (NEGL2_W'(1) << LOG_W)
                  - NEGL2_W'(frac_ff);
   assign hi_p  = (HI_W+LN2_W)'(negl2[NEGL2_W-1:LO_W]) * (HI_W+LN2_W)'(LN2_Q28);
   assign lo_p  = (LO_W+LN2_W)'(negl2[LO_W-1:0]) * (LO_W+LN2_W)'(LN2_Q28);
   assign rnd   = {1'b0, prod_ff} + ((PROD_W+1)'(1) << (ROUND_SH - 1));
   assign nl    = rnd[ROUND_SH +: NL_W];
   assign tp    = (PROB_W+NL_W)'(t_ff) * (PROB_W+NL_W)'(nl);
   assign ssum  = (LOSS_W+1)'(sacc_ff) + (LOSS_W+1)'(term_ff);
   assign bsum  = (BACC_W+1)'(bacc_ff) + (BACC_W+1)'(sacc_ff);
   assign mag   = (quo > (DVD_W'(1) << (GRAD_W-1))) ? (GRAD_W'(1) << (GRAD_W-1))
                                                    : quo[GRAD_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         t_ff    <= req_target_weight;
         n_ff    <= batch_n;
         lc_ff   <= req_last_class;
         ls_ff   <= req_last_sample;
         e_ff    <= e_in;
         y_ff    <= y_in;
         frac_ff <= '0;
         lcnt_ff <= '0;
         sl_ff   <= '0;
         avg_ff  <= '0;
      end else if (lbusy_ff) begin
         y_ff    <= sq_s[31] ? sq_s[31:1] : sq_s[30:0];
         frac_ff <= {frac_ff[LOG_W-2:0], sq_s[31]};
         lcnt_ff <= lcnt_ff + 1'b1;
      end
      if (cmd.keep_grad) grad_ff <= GRAD_W'(0) - mag;
      if (cmd.ln_hi)     prod_ff <= PROD_W'(hi_p) << LO_W;
      if (cmd.ln_lo)     prod_ff <= prod_ff + PROD_W'(lo_p);
      if (cmd.term) begin
         term_ff <= TERM_W'((tp + (PROB_W+NL_W)'(1 << (FRAC_BITS-1))) >> FRAC_BITS);
      end
      if (cmd.close)     sl_ff <= sacc_ff;
      if (cmd.avg_keep) begin
         avg_ff <= (quo > DVD_W'({LOSS_W{1'b1}})) ? '1 : quo[LOSS_W-1:0];
      end
      if (cmd.out_load) begin
         og_ff   <= grad_ff;
         osl_ff  <= sl_ff;
         osd_ff  <= lc_ff;
         oavg_ff <= avg_ff;
         obd_ff  <= lc_ff & ls_ff;
      end

      if (reset) begin
         lbusy_ff <= 1'b0;
         sacc_ff  <= '0;
         bacc_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         if (cmd.load) begin
            lbusy_ff <= 1'b1;
         end else if (lbusy_ff && lcnt_ff == 5'(LOG_W - 1)) begin
            lbusy_ff <= 1'b0;
         end
         if (cmd.acc) begin
            sacc_ff <= ssum[LOSS_W] ? '1 : ssum[LOSS_W-1:0];
         end else if (cmd.close) begin
            sacc_ff <= '0;
         end
         if (cmd.close) begin
            bacc_ff <= bsum[BACC_W] ? '1 : bsum[BACC_W-1:0];
         end else if (cmd.avg_keep) begin
            bacc_ff <= '0;
         end
         if (cmd.out_load) begin
            ov_ff <= 1'b1;
         end else if (rsp_ready) begin
            ov_ff <= 1'b0;
         end
      end
   end

   assign stat.div_busy    = div_busy;
   assign stat.log_busy    = lbusy_ff;
   assign stat.last_class  = lc_ff;
   assign stat.last_sample = ls_ff;
   assign stat.out_free    = ~ov_ff | rsp_ready;

   assign rsp_valid        = ov_ff;
   assign rsp_gradient     = og_ff;
   assign rsp_sample_loss  = osl_ff;
   assign rsp_sample_done  = osd_ff;
   assign rsp_batch_mean   = oavg_ff;
   assign rsp_batch_done   = obd_ff;
endmodule

/* rtl/core/ce_ctrl.sv */
// ce_ctrl: controller state machine sequencing the datapath per element.
// Depends on ce_pkg for command and status structs.
module ce_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ce_pkg::stat_type stat,
   output ce_pkg::cmd_type  cmd
);
   import ce_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_RUN    = 10'b0000000010,
      S_LNHI   = 10'b0000000100,
      S_LNLO   = 10'b0000001000,
      S_TERM   = 10'b0000010000,
      S_ACC    = 10'b0000100000,
      S_CLOSE  = 10'b0001000000,
      S_AVGST  = 10'b0010000000,
      S_AVGWT  = 10'b0100000000,
      S_FIN    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (!stat.div_busy && !stat.log_busy) begin
               cmd.keep_grad = 1'b1;
               state_in      = S_LNHI;
            end
         end
         S_LNHI: begin
            cmd.ln_hi = 1'b1;
            state_in  = S_LNLO;
         end
         S_LNLO: begin
            cmd.ln_lo = 1'b1;
            state_in  = S_TERM;
         end
         S_TERM: begin
            cmd.term = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = stat.last_class ? S_CLOSE : S_FIN;
         end
         S_CLOSE: begin
            cmd.close = 1'b1;
            state_in  = stat.last_sample ? S_AVGST : S_FIN;
         end
         S_AVGST: begin
            cmd.avg_start = 1'b1;
            state_in      = S_AVGWT;
         end
         S_AVGWT: begin
            if (!stat.div_busy) begin
               cmd.avg_keep = 1'b1;
               state_in     = S_FIN;
            end
         end
         S_FIN: begin
            // hold until the output register can take the word
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

/* rtl/core/cross_entropy_loss_and_gradient.sv */
// cross_entropy_loss_and_gradient: top level, batch size register, controller
// and datapath. Depends on ce_pkg, ce_req_if, ce_rsp_if, ce_ctrl and ce_dp.
//
// Usage:
//  - req_chan carries one word per class element: prob and target_weight in
//    unsigned Q1.16, last_class on the final class of a sample, last_sample on
//    the elements of the final sample of a batch.
//  - rsp_chan returns one word per request word: gradient -t/(p*N) in Q17.16,
//    plus sample_loss/sample_done on a last_class word and batch_mean/
//    batch_done when last_class and last_sample are both set.
//  - csr_we/csr_wdata write the batch size N (0 acts as 1); write it only
//    while no word is in flight.
//  - Processing of an ordinary word: a 40-step serial divider, run beside the
//    30-step log squaring unit, then S_LNHI, S_LNLO, S_TERM, S_ACC and S_FIN
//    for the loss term and output; a last_class word adds S_CLOSE, and on the
//    last word of a batch the same divider then forms the mean.
//  - One word in work at a time; the next is accepted the cycle after the
//    result enters the output register.
//  - Reset clears the accumulators, sets N to 1 and empties the output.
//  - A stalled receiver holds the output word; the block then parks after
//    finishing the next word until the output register frees up.
module cross_entropy_loss_and_gradient (
   input  logic                        clock,
   input  logic                        reset,
   ce_req_if.sink                      req_chan,
   ce_rsp_if.source                    rsp_chan,
   input  logic                        csr_we,
   input  logic [ce_pkg::PROB_W-1:0]   csr_wdata
);
   import ce_pkg::*;

   logic [PROB_W-1:0] bs_ff;
   logic [PROB_W-1:0] batch_n;
   cmd_type           cmd;
   stat_type          stat;

   // batch size register
   always_ff @(posedge clock) begin
      if (reset) begin
         bs_ff <= BATCH_SIZE_RESET;
      end else if (csr_we) begin
         bs_ff <= csr_wdata;
      end
   end

   // treat zero as one
   assign batch_n = (bs_ff == '0) ? PROB_W'(1) : bs_ff;

   ce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ce_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_prob          (req_chan.prob),
      .req_target_weight (req_chan.target_weight),
      .req_last_class    (req_chan.last_class),
      .req_last_sample   (req_chan.last_sample),
      .batch_n           (batch_n),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_gradient      (rsp_chan.gradient),
      .rsp_sample_loss   (rsp_chan.sample_loss),
      .rsp_sample_done   (rsp_chan.sample_done),
      .rsp_batch_mean    (rsp_chan.batch_mean),
      .rsp_batch_done    (rsp_chan.batch_done)
   );

   // drop ready right after an accepted word
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("second word accepted while one is in work");

   // a batch result comes only with a sample result
   a_batch_has_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.batch_done |-> rsp_chan.sample_done)
      else $error("batch_done without sample_done");

   // sample_loss is zero unless flagged
   a_loss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.sample_done |-> rsp_chan.sample_loss == '0)
      else $error("sample_loss set without sample_done");

   // gradient is never positive
   a_grad_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.gradient[GRAD_W-1] || rsp_chan.gradient == '0))
      else $error("positive gradient");
endmodule
